FILE: sv/sls_pkg.sv
// ----------------------------------------------------------------------------
// sls_pkg
// Shared operation and status codes and the control bundle that the sorted
// list store broadcasts to its row of cells.
// ----------------------------------------------------------------------------
package sls_pkg;

  localparam int VAL_W = 32;
  localparam int OP_W  = 3;
  localparam int IDX_W = 4;
  localparam int ST_W  = 2;
  localparam int CNT_W = 5;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_MIN = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_MAX = 3'd2;
  localparam logic [OP_W-1:0] OP_READ    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                    ins;
    logic                    shift;
    logic signed [VAL_W-1:0] value;
  } sls_ctrl_t;

endpackage

FILE: sv/sls_req_if.sv
// ----------------------------------------------------------------------------
// sls_req_if
// Request channel of the sorted list store: one operation per request.
// ----------------------------------------------------------------------------
interface sls_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [31:0] value;
  logic [3:0]         index;

  modport source (output valid, output operation, output value, output index, input ready);
  modport sink (input valid, input operation, input value, input index, output ready);
endinterface

FILE: sv/sls_rsp_if.sv
// ----------------------------------------------------------------------------
// sls_rsp_if
// Response channel of the sorted list store: status, value and count.
// ----------------------------------------------------------------------------
interface sls_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] result_value;
  logic [4:0]         entry_count;

  modport source (output valid, output status, output result_value, output entry_count,
                  input ready);
  modport sink (input valid, input status, input result_value, input entry_count,
                output ready);
endinterface

FILE: sv/sorted_list_store_core.sv
// ----------------------------------------------------------------------------
// sorted_list_store_core
// Double-ended priority queue holding up to DEPTH signed values in ascending
// order in a row of cells.
// ----------------------------------------------------------------------------
// Each request is one operation: insert (after equal values), remove the
// smallest, remove the largest, read at an index, or clear. Every request
// produces exactly one response with a status, a value and the count after
// the operation. A request is applied when accepted: every cell compares its
// own value against the inserted one and shifts in the same cycle, and one
// read port over the row supplies the removed or read value. The response
// sits in an output register, so a new request is accepted in each cycle
// in which the previous response is taken or none is pending. Unused
// operation codes leave the store unchanged and answer ok with a zero value.
// ----------------------------------------------------------------------------
module sorted_list_store_core import sls_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic  clk,
  input  logic  rst,
  sls_req_if.sink   req,
  sls_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic                    accept;
  logic                    full;
  logic                    empty;
  sls_ctrl_t               ctrl;
  logic [IW-1:0]           rd_sel;
  logic signed [VAL_W-1:0] rd_data;
  logic [ST_W-1:0]         status_next;
  logic signed [VAL_W-1:0] result_next;
  logic                    gt_row  [DEPTH];
  logic signed [VAL_W-1:0] val_row [DEPTH];

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = count == CW'(DEPTH);
  assign empty     = count == '0;

  always_comb begin
    ctrl.ins   = accept && (req.operation == OP_INSERT) && !full;
    ctrl.shift = accept && (req.operation == OP_POP_MIN) && !empty;
    ctrl.value = req.value;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    p_gt;
    logic signed [VAL_W-1:0] p_val;
    logic signed [VAL_W-1:0] n_val;
    if (i == 0) begin : g_first
      assign p_gt  = 1'b0;
      assign p_val = '0;
    end else begin : g_mid
      assign p_gt  = gt_row[i-1];
      assign p_val = val_row[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign n_val = val_row[i];
    end else begin : g_inner
      assign n_val = val_row[i+1];
    end
    sls_cell #(.CW(CW), .IDX(i)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .prev_gt    (p_gt),
      .prev_value (p_val),
      .next_value (n_val),
      .gt         (gt_row[i]),
      .value      (val_row[i])
    );
  end

  always_comb begin
    unique case (req.operation)
      OP_READ:    rd_sel = IW'(req.index);
      OP_POP_MAX: rd_sel = IW'(count - CW'(1));
      default:    rd_sel = '0;
    endcase
    rd_data = val_row[rd_sel];
  end

  always_comb begin
    status_next = ST_OK;
    result_next = '0;
    count_next  = count;
    unique case (req.operation) inside
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      OP_POP_MIN, OP_POP_MAX: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          result_next = rd_data;
          count_next  = count - CW'(1);
        end
      end
      OP_READ: begin
        if (XW'(req.index) >= XW'(count)) begin
          status_next = ST_EMPTY;
        end else begin
          result_next = rd_data;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status       <= status_next;
      rsp.result_value <= result_next;
      rsp.entry_count  <= CNT_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && (req.operation == OP_INSERT) && !full |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the count");

  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.entry_count == CNT_W'(count))
    else $error("response count disagrees with stored count");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_FULL) |-> full)
    else $error("full status while store not full");

endmodule

FILE: sv/sls_cell.sv
// ----------------------------------------------------------------------------
// sls_cell
// One slot of the sorted row. It compares its value with the one being
// inserted and takes its left neighbor's value, the new value, or its right
// neighbor's value as the broadcast operation requires.
// ----------------------------------------------------------------------------
module sls_cell import sls_pkg::*; #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  sls_ctrl_t               ctrl,
  input  logic [CW-1:0]           count,
  input  logic                    prev_gt,
  input  logic signed [VAL_W-1:0] prev_value,
  input  logic signed [VAL_W-1:0] next_value,
  output logic                    gt,
  output logic signed [VAL_W-1:0] value
);

  logic live;
  logic at_end;

  always_comb begin
    live   = CW'(IDX) < count;
    at_end = CW'(IDX) == count;
    gt     = live && (value > ctrl.value);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (prev_gt) begin
        value <= prev_value;
      end else if (gt || at_end) begin
        value <= ctrl.value;
      end
    end else if (ctrl.shift) begin
      value <= next_value;
    end
  end

endmodule
